@@ hdl/stt_pkg.sv @@
package stt_pkg;

	// table geometry
	localparam int ENTRIES    = 10;
	localparam int NAME_CHARS = 8;

	// field widths
	localparam int SCORE_W = 31;
	localparam int NAME_W  = 64;
	localparam int HALF_W  = 16;
	localparam int IDX_W   = 6;
	localparam int POS_W   = 4;
	localparam int CMD_W   = 2;

	localparam logic [NAME_W-1:0] RESET_TAG = 64'h0000_0000_0041_4141;

	typedef enum logic [CMD_W-1:0] {
		CMD_CHECK  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	// one stored record
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [NAME_W-1:0]  name;
		logic [HALF_W-1:0]  level;
		logic [HALF_W-1:0]  stage;
	} rec_t;

	// keep the low NAME_CHARS bytes, stopping at the first zero byte
	function automatic logic [NAME_W-1:0] cut_tag(input logic [NAME_W-1:0] tag);
		logic [NAME_W-1:0] r;
		logic              live;
		r    = '0;
		live = 1'b1;
		for (int b = 0; b < NAME_CHARS; b++) begin
			if (tag[8*b +: 8] == 8'h00)
				live = 1'b0;
			if (live)
				r[8*b +: 8] = tag[8*b +: 8];
		end
		return r;
	endfunction

	localparam logic [NAME_W-1:0] RESET_NAME = cut_tag(RESET_TAG);

endpackage

@@ hdl/stt_cell.sv @@
module stt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          insert_en,
	input  logic          gt_prev,
	input  stt_pkg::rec_t new_rec,
	input  stt_pkg::rec_t prev_rec,
	output logic          gt,
	output stt_pkg::rec_t rec
);
	import stt_pkg::*;

	rec_t rec_q;

	// offered score strictly beats this slot
	assign gt  = new_rec.score > rec_q.score;
	assign rec = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q.score <= '0;
			rec_q.name  <= RESET_NAME;
			rec_q.level <= '0;
			rec_q.stage <= '0;
		end else if (insert_en && gt) begin
			// upper neighbour also displaced: take its record, else take the new one
			rec_q <= gt_prev ? prev_rec : new_rec;
		end
	end

endmodule

@@ hdl/sorted_top_n_score_table_top.sv @@
// an accepted transaction's result is held on the output register from the next cycle
// throughput: one check, insert or read transaction per cycle while the output is not stalled
// the rate is set by the cell row: every cell compares and shifts in the same cycle
// reset (arst_n low, asynchronous): scores, levels and stages clear to zero,
// name tags load "AAA", the output register is emptied
module sorted_top_n_score_table_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [stt_pkg::CMD_W-1:0]   command,
	input  logic [stt_pkg::SCORE_W-1:0] score,
	input  logic [stt_pkg::NAME_W-1:0]  name_tag,
	input  logic [stt_pkg::HALF_W-1:0]  level,
	input  logic [stt_pkg::HALF_W-1:0]  stage,
	input  logic [stt_pkg::IDX_W-1:0]   entry_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        qualifies,
	output logic [stt_pkg::POS_W-1:0]   position,
	output logic                        index_error,
	output logic [stt_pkg::SCORE_W-1:0] entry_score,
	output logic [stt_pkg::NAME_W-1:0]  entry_name,
	output logic [stt_pkg::HALF_W-1:0]  entry_level,
	output logic [stt_pkg::HALF_W-1:0]  entry_stage
);
	import stt_pkg::*;

	// handshake
	logic accept;
	logic out_valid_q;

	// cell row
	rec_t             new_rec;
	rec_t             cell_rec [ENTRIES];
	logic [ENTRIES-1:0] cell_gt;
	logic             insert_en;

	// result computed this cycle
	logic             res_qual;
	logic [POS_W-1:0] res_pos;
	logic             res_ierr;
	rec_t             res_rec;
	logic [POS_W-1:0] first_pos;
	rec_t             rd_rec;

	// output register
	logic             qual_q;
	logic [POS_W-1:0] pos_q;
	logic             ierr_q;
	rec_t             rec_q;

	// a new transaction is taken whenever the output register is free or being emptied
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign insert_en = accept && (command == CMD_INSERT);

	// record offered for insertion, tag already trimmed
	assign new_rec.score = score;
	assign new_rec.name  = cut_tag(name_tag);
	assign new_rec.level = level;
	assign new_rec.stage = stage;

	// row of cells, slot 0 holds the highest score; each cell sees only its upper neighbour
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			stt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.insert_en (insert_en),
				.gt_prev   (1'b0),
				.new_rec   (new_rec),
				.prev_rec  (new_rec),
				.gt        (cell_gt[i]),
				.rec       (cell_rec[i])
			);
		end else begin : g_body
			stt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.insert_en (insert_en),
				.gt_prev   (cell_gt[i-1]),
				.new_rec   (new_rec),
				.prev_rec  (cell_rec[i-1]),
				.gt        (cell_gt[i]),
				.rec       (cell_rec[i])
			);
		end
	end

	// the table is sorted, so the gt flags form one run reaching the bottom slot:
	// the insert slot is the only cell whose flag is set and its neighbour's is not,
	// and the bottom flag alone says whether the score qualifies
	always_comb begin
		first_pos = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (cell_gt[i] && (i == 0 || !cell_gt[(i == 0) ? 0 : i-1]))
				first_pos = first_pos | POS_W'(i);
		end
	end

	// read port as an and-or select over the cells
	always_comb begin
		rd_rec = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (entry_index == IDX_W'(i))
				rd_rec = rd_rec | cell_rec[i];
		end
	end

	// result fields by command; unused fields are zero, position defaults to ENTRIES
	always_comb begin
		res_qual = 1'b0;
		res_pos  = POS_W'(ENTRIES);
		res_ierr = 1'b0;
		res_rec  = '0;
		case (command)
			CMD_CHECK: begin
				res_qual = cell_gt[ENTRIES-1];
			end
			CMD_INSERT: begin
				res_qual = cell_gt[ENTRIES-1];
				if (cell_gt[ENTRIES-1])
					res_pos = first_pos;
			end
			CMD_READ: begin
				if (7'(entry_index) >= 7'(ENTRIES))
					res_ierr = 1'b1;
				else
					res_rec = rd_rec;
			end
			default: begin
				// spare command code: the table is left unchanged and the default result is registered
				res_qual = 1'b0;
			end
		endcase
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			qual_q <= res_qual;
			pos_q  <= res_pos;
			ierr_q <= res_ierr;
			rec_q  <= res_rec;
		end
	end

	assign out_valid   = out_valid_q;
	assign qualifies   = qual_q;
	assign position    = pos_q;
	assign index_error = ierr_q;
	assign entry_score = rec_q.score;
	assign entry_name  = rec_q.name;
	assign entry_level = rec_q.level;
	assign entry_stage = rec_q.stage;

	// the row must stay sorted by descending score
	for (genvar i = 1; i < ENTRIES; i++) begin : g_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			cell_rec[i-1].score >= cell_rec[i].score)
			else $error("score table out of order");
	end

	// backpressure only while a result is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty output register");

	// every accepted transaction leaves a result behind
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted transaction produced no result");

	// an out-of-range read carries no record
	a_ierr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ierr_q) |-> (rec_q == '0 && !qual_q))
		else $error("index error with non-zero record");

endmodule
